### design/base64_stream_encoder_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define B64ENC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("b64enc: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define B64ENC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("b64enc: next-cycle check failed");

`endif

### design/b64enc_pkg.sv
// Shared types and constants of the Base64 stream encoder.
package b64enc_pkg;

    // Reset values of the configuration registers
    localparam logic [7:0] PAD_RESET = 8'd61;
    localparam logic [7:0] SEP_RESET = 8'd32;
    localparam logic [3:0] GPS_RESET = 4'd2;

    // Configuration register indexes (word address)
    typedef enum logic [1:0] {
        REG_PAD = 2'd0,
        REG_SEP = 2'd1,
        REG_GPS = 2'd2
    } reg_idx_t;

    // Request kinds on the input channel
    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Output queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One encoded character on its way out
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } out_entry_t;

endpackage

### design/base64_stream_encoder.sv
// A group-ending byte passes the job registers, read stage and output queue on its way to m_.
// Throughput: one character per cycle while the output queue has room; a group-ending byte
// yields four characters, or five with a separator; the next request waits for its last one.
// The single alphabet read port, one character per cycle, sets the rate.
// Reset (synchronous, aresetn low) clears the stream state, queue and registers to
// their defaults; the alphabet is not cleared and must be written before use.
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_last,
    input  logic [5:0]  s_table_index,
    input  logic [7:0]  s_table_char,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_of_run
);

    // Configuration registers
    logic [7:0]  pad_char_reg;
    logic [7:0]  sep_char_reg;
    logic [3:0]  gps_reg;

    // Stream state
    logic [15:0] byte_buf_reg, byte_buf_next;
    logic [1:0]  bytes_held_reg, bytes_held_next;
    logic [3:0]  group_cnt_reg, group_cnt_next;

    // Pending job: one group's characters
    logic        job_valid_reg;
    logic [23:0] job_word_reg;
    logic [2:0]  job_sext_reg;
    logic [2:0]  job_cnt_reg;
    logic [2:0]  job_pos_reg;

    // Job built from the current request
    logic        new_job;
    logic [23:0] new_word;
    logic [2:0]  new_sext;
    logic        new_sep;
    logic [4:0]  group_inc;

    // Issue stage
    logic        issue;
    logic        job_done;
    logic [5:0]  rd_addr;
    logic        slot_lit;
    logic [7:0]  slot_char;
    logic        slot_last;

    // Read stage
    logic        s1_valid_reg;
    logic        s1_lit_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_last_reg;
    logic [7:0]  rd_data_reg;

    // Alphabet memory
    logic [7:0]  alpha_mem [64];

    // Output queue
    b64enc_pkg::out_entry_t               push_entry;
    b64enc_pkg::out_entry_t               pop_entry;
    logic [b64enc_pkg::FIFO_CNT_W-1:0]    fifo_count;

    logic        in_accept;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_accept = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_char_reg <= b64enc_pkg::PAD_RESET;
            sep_char_reg <= b64enc_pkg::SEP_RESET;
            gps_reg      <= b64enc_pkg::GPS_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                b64enc_pkg::REG_PAD: pad_char_reg <= pwdata[7:0];
                b64enc_pkg::REG_SEP: sep_char_reg <= pwdata[7:0];
                b64enc_pkg::REG_GPS: gps_reg      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        unique case (paddr[3:2])
            b64enc_pkg::REG_PAD: prdata = {24'd0, pad_char_reg};
            b64enc_pkg::REG_SEP: prdata = {24'd0, sep_char_reg};
            b64enc_pkg::REG_GPS: prdata = {28'd0, gps_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Gather bytes and build the group job
    always_comb begin
        byte_buf_next   = byte_buf_reg;
        bytes_held_next = bytes_held_reg;
        group_cnt_next  = group_cnt_reg;
        new_job         = 1'b0;
        new_word        = 24'd0;
        new_sext        = 3'd4;
        new_sep         = 1'b0;
        group_inc       = {1'b0, group_cnt_reg} + 5'd1;
        priority if (bytes_held_reg >= 2'd2) begin
            new_job         = 1'b1;
            new_word        = {byte_buf_reg, s_data_byte};
            new_sext        = 3'd4;
            byte_buf_next   = 16'd0;
            bytes_held_next = 2'd0;
            if (gps_reg != 4'd0) begin
                if (group_inc >= {1'b0, gps_reg}) begin
                    new_sep        = 1'b1;
                    group_cnt_next = 4'd0;
                end else begin
                    group_cnt_next = group_inc[3:0];
                end
            end else begin
                group_cnt_next = 4'd0;
            end
            if (s_is_last) begin
                group_cnt_next = 4'd0;
            end
        end else if (s_is_last) begin
            new_job = 1'b1;
            if (bytes_held_reg == 2'd0) begin
                new_word = {s_data_byte, 16'd0};
                new_sext = 3'd2;
            end else begin
                new_word = {byte_buf_reg[7:0], s_data_byte, 8'd0};
                new_sext = 3'd3;
            end
            byte_buf_next   = 16'd0;
            bytes_held_next = 2'd0;
            group_cnt_next  = 4'd0;
        end else begin
            byte_buf_next   = {byte_buf_reg[7:0], s_data_byte};
            bytes_held_next = bytes_held_reg + 2'd1;
        end
    end

    // Select the character slot at the job position
    always_comb begin
        unique case (job_pos_reg)
            3'd0:    rd_addr = job_word_reg[23:18];
            3'd1:    rd_addr = job_word_reg[17:12];
            3'd2:    rd_addr = job_word_reg[11:6];
            3'd3:    rd_addr = job_word_reg[5:0];
            default: rd_addr = 6'd0;
        endcase
        slot_lit  = (job_pos_reg >= job_sext_reg);
        slot_char = (job_pos_reg >= 3'd4) ? sep_char_reg : pad_char_reg;
        slot_last = ((job_pos_reg + 3'd1) == job_cnt_reg);
    end

    // Issue one character a cycle while the queue has room for it
    assign issue    = job_valid_reg &&
                      ((fifo_count + {{(b64enc_pkg::FIFO_CNT_W-1){1'b0}}, s1_valid_reg})
                       < b64enc_pkg::FIFO_CNT_W'(b64enc_pkg::FIFO_DEPTH));
    assign job_done = issue && slot_last;
    assign s_ready  = !job_valid_reg || job_done;

    // Stream state and job registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_buf_reg   <= 16'd0;
            bytes_held_reg <= 2'd0;
            group_cnt_reg  <= 4'd0;
            job_valid_reg  <= 1'b0;
            job_pos_reg    <= 3'd0;
        end else begin
            if (in_accept && s_mode == b64enc_pkg::MODE_DATA) begin
                byte_buf_reg   <= byte_buf_next;
                bytes_held_reg <= bytes_held_next;
                group_cnt_reg  <= group_cnt_next;
            end
            if (in_accept && s_mode == b64enc_pkg::MODE_DATA && new_job) begin
                job_valid_reg <= 1'b1;
                job_pos_reg   <= 3'd0;
            end else if (job_done) begin
                job_valid_reg <= 1'b0;
                job_pos_reg   <= 3'd0;
            end else if (issue) begin
                job_pos_reg <= job_pos_reg + 3'd1;
            end
        end
    end

    // Hold job payload
    always_ff @(posedge aclk) begin
        if (in_accept && s_mode == b64enc_pkg::MODE_DATA && new_job) begin
            job_word_reg <= new_word;
            job_sext_reg <= new_sext;
            job_cnt_reg  <= new_sep ? 3'd5 : 3'd4;
        end
    end

    // Alphabet memory: write on load requests, registered read on issue
    always_ff @(posedge aclk) begin
        if (in_accept && s_mode == b64enc_pkg::MODE_WRITE) begin
            alpha_mem[s_table_index] <= s_table_char;
        end
        if (issue) begin
            rd_data_reg <= alpha_mem[rd_addr];
        end
    end

    // Read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_lit_reg  <= slot_lit;
            s1_char_reg <= slot_char;
            s1_last_reg <= slot_last;
        end
    end

    assign push_entry.out_char    = s1_lit_reg ? s1_char_reg : rd_data_reg;
    assign push_entry.last_of_run = s1_last_reg;

    b64enc_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s1_valid_reg),
        .push_entry (push_entry),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_entry  (pop_entry),
        .count      (fifo_count)
    );

    assign m_out_char    = pop_entry.out_char;
    assign m_last_of_run = pop_entry.last_of_run;

    // Checks
    `B64ENC_ASSERT_SAME(a_push_room, aclk, aresetn, s1_valid_reg, fifo_count < b64enc_pkg::FIFO_CNT_W'(b64enc_pkg::FIFO_DEPTH))
    `B64ENC_ASSERT_NEXT(a_job_rewind, aclk, aresetn, job_done, job_pos_reg == 3'd0)
    `B64ENC_ASSERT_SAME(a_pos_bound, aclk, aresetn, job_valid_reg, job_pos_reg < job_cnt_reg)
    `B64ENC_ASSERT_SAME(a_held_bound, aclk, aresetn, 1'b1, bytes_held_reg != 2'd3)

endmodule

### design/b64enc_out_fifo.sv
// Small output queue that decouples character issue from the result channel.
module b64enc_out_fifo (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  push_valid,
    input  b64enc_pkg::out_entry_t                push_entry,
    output logic                                  pop_valid,
    input  logic                                  pop_ready,
    output b64enc_pkg::out_entry_t                pop_entry,
    output logic [b64enc_pkg::FIFO_CNT_W-1:0]     count
);

    b64enc_pkg::out_entry_t                store_reg [b64enc_pkg::FIFO_DEPTH];
    logic [b64enc_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [b64enc_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [b64enc_pkg::FIFO_CNT_W-1:0]     count_reg, count_next;
    logic                                  pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_entry = store_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry data
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### sim/base64_stream_encoder_tb.sv
// Self-checking testbench for the Base64 stream encoder: random streams against a local predictor.
module base64_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One request on the input channel
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       is_last;
        logic [5:0] table_index;
        logic [7:0] table_char;
    } enc_request_t;

    // Predicts the character stream and checks what comes out of the block
    class encoder_scoreboard;
        logic [7:0]  alphabet [64];
        logic [15:0] held_bytes;
        logic [1:0]  held_count;
        logic [3:0]  group_count;
        logic [7:0]  pad_char;
        logic [7:0]  sep_char;
        logic [3:0]  groups_per_sep;
        b64enc_pkg::out_entry_t expected_chars [$];
        int          mismatches;
        int          requests;
        int          messages;
        int          chars_checked;
        int          separators;

        function new();
            held_bytes     = '0;
            held_count     = '0;
            group_count    = '0;
            pad_char       = b64enc_pkg::PAD_RESET;
            sep_char       = b64enc_pkg::SEP_RESET;
            groups_per_sep = b64enc_pkg::GPS_RESET;
            mismatches     = 0;
            requests       = 0;
            messages       = 0;
            chars_checked  = 0;
            separators     = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void set_register(b64enc_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                b64enc_pkg::REG_PAD: pad_char = value[7:0];
                b64enc_pkg::REG_SEP: sep_char = value[7:0];
                b64enc_pkg::REG_GPS: groups_per_sep = value[3:0];
                default: ;
            endcase
        endfunction

        function void push_char(logic [7:0] ch);
            b64enc_pkg::out_entry_t e;
            e.out_char    = ch;
            e.last_of_run = 1'b0;
            expected_chars.push_back(e);
        endfunction

        // Work out the characters one accepted request causes
        function void encode_request(enc_request_t r);
            int         before_count;
            logic [23:0] word;
            before_count = expected_chars.size();
            requests++;
            if (r.mode == b64enc_pkg::MODE_WRITE) begin
                alphabet[r.table_index] = r.table_char;
                return;
            end
            if (r.is_last)
                messages++;
            if (held_count >= 2) begin
                // Full group: four characters, then maybe a separator
                word = {held_bytes, r.data_byte};
                push_char(alphabet[word[23:18]]);
                push_char(alphabet[word[17:12]]);
                push_char(alphabet[word[11:6]]);
                push_char(alphabet[word[5:0]]);
                held_bytes = '0;
                held_count = '0;
                if (groups_per_sep != 0) begin
                    if (int'(group_count) + 1 >= int'(groups_per_sep)) begin
                        push_char(sep_char);
                        separators++;
                        group_count = '0;
                    end else begin
                        group_count = group_count + 4'd1;
                    end
                end else begin
                    group_count = '0;
                end
                if (r.is_last)
                    group_count = '0;
            end else if (r.is_last) begin
                // Partial group: zero-fill and pad
                if (held_count == 0) begin
                    word = {r.data_byte, 16'h0000};
                    push_char(alphabet[word[23:18]]);
                    push_char(alphabet[word[17:12]]);
                    push_char(pad_char);
                    push_char(pad_char);
                end else begin
                    word = {held_bytes[7:0], r.data_byte, 8'h00};
                    push_char(alphabet[word[23:18]]);
                    push_char(alphabet[word[17:12]]);
                    push_char(alphabet[word[11:6]]);
                    push_char(pad_char);
                end
                held_bytes  = '0;
                held_count  = '0;
                group_count = '0;
            end else begin
                held_bytes = {held_bytes[7:0], r.data_byte};
                held_count = held_count + 2'd1;
            end
            if (expected_chars.size() > before_count)
                expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one character from the block with the oldest expectation
        task check_result(logic [7:0] ch, logic last);
            b64enc_pkg::out_entry_t e;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", ch));
                return;
            end
            e = expected_chars.pop_front();
            chars_checked++;
            if (ch !== e.out_char)
                report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                          ch, e.out_char));
            if (last !== e.last_of_run)
                report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                          last, e.last_of_run));
        endtask

        task flush_leftovers();
            while (expected_chars.size() != 0) begin
                report_mismatch($sformatf("character 0x%02h never arrived",
                                          expected_chars[0].out_char));
                void'(expected_chars.pop_front());
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_mode        = b64enc_pkg::MODE_DATA;
    logic [7:0]  s_data_byte   = '0;
    logic        s_is_last     = 1'b0;
    logic [5:0]  s_table_index = '0;
    logic [7:0]  s_table_char  = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_last_of_run;

    encoder_scoreboard sb = new();
    int idle_pct    = 17;
    int bytes_to_go = 0;
    int settings_run = 0;

    base64_stream_encoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_data_byte   (s_data_byte),
        .s_is_last     (s_is_last),
        .s_table_index (s_table_index),
        .s_table_char  (s_table_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("base64_stream_encoder regression: fail");
        $finish;
    end

    // Take characters, stalling at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_char, m_last_of_run);
        m_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Standard Base64 alphabet for the first load
    function automatic logic [7:0] std_char(int i);
        if (i < 26) return 8'(65 + i);
        if (i < 52) return 8'(97 + i - 26);
        if (i < 62) return 8'(48 + i - 52);
        if (i == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    // Present one request and hold it until accepted
    task send_request(enc_request_t r);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= r.mode;
        s_data_byte   <= r.data_byte;
        s_is_last     <= r.is_last;
        s_table_index <= r.table_index;
        s_table_char  <= r.table_char;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.encode_request(r);
    endtask

    task send_data(logic [7:0] b, logic last);
        enc_request_t r;
        r.mode        = b64enc_pkg::MODE_DATA;
        r.data_byte   = b;
        r.is_last     = last;
        r.table_index = 6'($urandom_range(0, 63));
        r.table_char  = 8'($urandom_range(0, 255));
        send_request(r);
    endtask

    task send_entry(logic [5:0] idx, logic [7:0] ch);
        enc_request_t r;
        r.mode        = b64enc_pkg::MODE_WRITE;
        r.data_byte   = 8'($urandom_range(0, 255));
        r.is_last     = 1'($urandom_range(0, 1));
        r.table_index = idx;
        r.table_char  = ch;
        send_request(r);
    endtask

    // Mostly whole messages of random length, some long, a few cut short
    task send_random();
        if ($urandom_range(0, 99) < 6) begin
            send_entry(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end else begin
            if (bytes_to_go == 0)
                bytes_to_go = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                          : $urandom_range(1, 12);
            bytes_to_go--;
            if ($urandom_range(0, 99) < 3)
                bytes_to_go = 0;
            send_data(8'($urandom_range(0, 255)), bytes_to_go == 0);
        end
    endtask

    task apb_write(b64enc_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid and let the block go quiet before touching registers
    task wait_for_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task run_directed();
        // Full group, then a second one that reaches the separator count
        send_data(8'h4D, 1'b0);
        send_data(8'h61, 1'b0);
        send_data(8'h6E, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'h00, 1'b0);
        // Full group closing the message
        send_data(8'hFF, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hFF, 1'b1);
        // One and two byte tails
        send_data(8'hFF, 1'b1);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
        // Alphabet write in the middle of a group
        send_data(8'h80, 1'b0);
        send_entry(6'd63, 8'h5F);
        send_data(8'h3F, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'h01, 1'b1);
        // Message ending on the group that hits the separator count
        send_data(8'h12, 1'b0);
        send_data(8'h34, 1'b0);
        send_data(8'h56, 1'b0);
        send_data(8'hAB, 1'b0);
        send_data(8'hCD, 1'b0);
        send_data(8'hEF, 1'b1);
    endtask

    initial begin : stimulus
        int          phase;
        int          guard;
        logic [7:0]  pad_v;
        logic [7:0]  sep_v;
        logic [3:0]  gps_v;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every alphabet entry before any byte is encoded
        for (int i = 0; i < 64; i++)
            send_entry(6'(i), std_char(i));
        run_directed();
        settings_run = 1;

        // Random phases, each with its own register settings
        for (phase = 0; phase < 8; phase++) begin
            wait_for_drain();
            pad_v = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            sep_v = (phase == 0) ? 8'hFF : (phase == 1) ? 8'h00 : 8'($urandom_range(0, 255));
            case (phase)
                0:       gps_v = 4'd0;
                1:       gps_v = 4'd15;
                2:       gps_v = 4'd1;
                3:       gps_v = 4'd4;
                4:       gps_v = 4'd2;
                default: gps_v = 4'($urandom_range(0, 15));
            endcase
            apb_write(b64enc_pkg::REG_PAD, {24'h0, pad_v});
            apb_write(b64enc_pkg::REG_SEP, {24'h0, sep_v});
            apb_write(b64enc_pkg::REG_GPS, {28'h0, gps_v});
            settings_run++;
            idle_pct = (phase == 3) ? 0 : 17;
            repeat (35) send_random();
        end

        // Drain with a bound, then settle
        s_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        sb.flush_leftovers();

        $display("covered %0d requests, %0d messages, %0d characters checked",
                 sb.requests, sb.messages, sb.chars_checked);
        $display("  including %0d separators across %0d register settings",
                 sb.separators, settings_run);
        if (sb.mismatches == 0)
            $display("base64_stream_encoder regression: pass");
        else
            $display("base64_stream_encoder regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/b64enc_pkg.sv
design/b64enc_out_fifo.sv
design/base64_stream_encoder.sv
sim/base64_stream_encoder_tb.sv
